// ===== sv/sparse_matrix_token_decoder_unit_defines.svh =====
// Assertion macros shared by the sparse matrix token decoder RTL.
// Depends on nothing; files that assert include it by name.
`ifndef SPARSE_MATRIX_TOKEN_DECODER_UNIT_DEFINES_SVH
`define SPARSE_MATRIX_TOKEN_DECODER_UNIT_DEFINES_SVH

// Clocked assertion, quiet while reset is held
`define SMTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SMTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/smtd_pkg.sv =====
// Shared types and constants of the sparse matrix token decoder.
// Depends on nothing.
package smtd_pkg;

  localparam int WIN_BITS = 192;

  typedef enum logic [1:0] {
    IN_DICT_LOAD = 2'd0,
    IN_START     = 2'd1,
    IN_STREAM    = 2'd2,
    IN_UNUSED    = 2'd3
  } in_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // input beat taken
    logic step;   // decode one token
    logic flush;  // hand the pending result over as the last one
  } smtd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic starts;     // beat is a stream word for a live matrix
    logic more;       // at least 16 bytes buffered
    logic emits;      // token at the front yields a result
    logic pend_valid; // a decoded result waits for the output register
    logic out_free;   // output register can take a result this cycle
  } smtd_sts_t;

  // Token length in bytes by token kind
  function automatic logic [3:0] token_len(input logic [2:0] tk);
    logic [3:0] len;
    case (tk)
      3'd0: len = 4'd1;
      3'd1: len = 4'd2;
      3'd2: len = 4'd3;
      3'd3: len = 4'd5;
      3'd4: len = 4'd7;
      3'd5: len = 4'd9;
      3'd6: len = 4'd11;
      default: len = 4'd14;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/smtd_if.sv =====
// Channel interfaces of the sparse matrix token decoder.
// Depends on nothing.
interface smtd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  dict_index;
  logic [63:0] data_word;
  modport source (output valid, kind, dict_index, data_word, input ready);
  modport sink (input valid, kind, dict_index, data_word, output ready);
endinterface

interface smtd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_index;
  logic [47:0] column_index;
  logic [63:0] value_bits;
  logic        new_column;
  logic        done_res;
  logic        last;
  modport source (output valid, result_index, column_index, value_bits, new_column,
                  done_res, last, input ready);
  modport sink (input valid, result_index, column_index, value_bits, new_column,
                done_res, last, output ready);
endinterface

// ===== sv/smtd_ctrl.sv =====
// Controller of the sparse matrix token decoder: idle and decode states.
// Depends on smtd_pkg.
module smtd_ctrl
  import smtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  smtd_sts_t sts,
  output smtd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_DECODE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Take input beats, sequence token steps and the final hand-over
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.starts) state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.more) begin
          if (!(sts.emits && sts.pend_valid && !sts.out_free)) cmd.step = 1'b1;
        end else if (sts.pend_valid) begin
          if (sts.out_free) begin
            cmd.flush = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== sv/smtd_datapath.sv =====
// Sparse matrix token decoder datapath: byte window, position counters,
// value dictionary, result registers. Depends on smtd_pkg, the defines.
`include "sparse_matrix_token_decoder_unit_defines.svh"
module smtd_datapath
  import smtd_pkg::*;
#(
  parameter int DICT_ENTRIES = 256,
  parameter int COLUMN_BITS  = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  smtd_cmd_t   cmd,
  output smtd_sts_t   sts,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_dict_index,
  input  logic [63:0] in_data_word,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_result_index,
  output logic [47:0] out_column_index,
  output logic [63:0] out_value_bits,
  output logic        out_new_column,
  output logic        out_done_res,
  output logic        out_last
);

  localparam int AW = $clog2(DICT_ENTRIES);

  // Stream state
  logic [WIN_BITS-1:0]    win_r, win_nxt;
  logic [4:0]             held_r, held_nxt;
  logic [3:0]             row_r, row_nxt;
  logic [27:0]            grp_r, grp_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, pcol_r, pcol_nxt;
  logic                   pvalid_r, pvalid_nxt, fin_r, fin_nxt;

  // Pending result, decoded but not yet in the output register
  logic                   pend_valid_r, pend_valid_nxt;
  logic [31:0]            pend_idx_r;
  logic [47:0]            pend_col_r;
  logic [63:0]            pend_val_r;
  logic                   pend_dict_r, pend_newcol_r, pend_done_r;

  // Dictionary and its registered read port
  logic [63:0] dict_mem [DICT_ENTRIES];
  logic [63:0] dict_q;

  logic [2:0]             tk;
  logic [4:0]             lo5;
  logic [44:0]            delta;
  logic [4:0]             row_sum;
  logic [COLUMN_BITS-1:0] col_step;
  logic [63:0]            col_ext;
  logic                   is_end, is_stream, push, dict_rd;
  logic [WIN_BITS-1:0]    appended, dropped;

  assign tk        = win_r[2:0];
  assign lo5       = win_r[7:3];
  assign is_end    = (win_r[127:0] == 128'd0);
  assign is_stream = (in_kind == IN_STREAM);

  // Gather the position delta by token kind
  always_comb begin
    case (tk)
      3'd2:    delta = {32'd0, win_r[23:16], lo5};
      3'd3:    delta = {16'd0, win_r[39:16], lo5};
      3'd4:    delta = {win_r[55:16], lo5};
      3'd6:    delta = {24'd0, win_r[87:72], lo5};
      3'd7:    delta = {win_r[111:72], lo5};
      default: delta = {40'd0, lo5};
    endcase
  end

  // Advance row, carry into column, then add the column step
  assign row_sum  = {1'b0, row_r} + {1'b0, delta[3:0]};
  assign col_step = col_r + COLUMN_BITS'(row_sum[4]) + COLUMN_BITS'(delta[44:4]);
  assign col_ext  = 64'(col_step);

  assign appended = win_r | (WIN_BITS'(in_data_word) << {held_r[3:0], 3'b000});
  assign dropped  = win_r >> {token_len(tk), 3'b000};

  assign sts.starts     = is_stream && !fin_r;
  assign sts.more       = (held_r >= 5'd16);
  assign sts.emits      = is_end || (tk != 3'd0);
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = !out_valid || out_ready;

  assign push    = cmd.flush || (cmd.step && sts.emits && pend_valid_r);
  assign dict_rd = cmd.step && !is_end && (tk != 3'd0) && (tk < 3'd5);

  // Next stream state
  always_comb begin
    win_nxt        = win_r;
    held_nxt       = held_r;
    row_nxt        = row_r;
    grp_nxt        = grp_r;
    col_nxt        = col_r;
    pcol_nxt       = pcol_r;
    pvalid_nxt     = pvalid_r;
    fin_nxt        = fin_r;
    pend_valid_nxt = pend_valid_r && !push;
    if (cmd.load) begin
      if (in_kind == IN_START) begin
        win_nxt    = '0;
        held_nxt   = '0;
        row_nxt    = '0;
        grp_nxt    = '0;
        col_nxt    = '0;
        pvalid_nxt = 1'b0;
        fin_nxt    = 1'b0;
      end else if (is_stream && !fin_r) begin
        win_nxt  = appended;
        held_nxt = held_r + 5'd8;
      end
    end else if (cmd.step) begin
      if (is_end) begin
        win_nxt        = '0;
        held_nxt       = '0;
        fin_nxt        = 1'b1;
        pend_valid_nxt = 1'b1;
      end else if (tk == 3'd0) begin
        grp_nxt  = grp_r + 28'd1;
        row_nxt  = '0;
        col_nxt  = '0;
        win_nxt  = dropped;
        held_nxt = held_r - 5'(token_len(tk));
      end else begin
        row_nxt        = row_sum[3:0];
        col_nxt        = col_step;
        pcol_nxt       = col_step;
        pvalid_nxt     = 1'b1;
        win_nxt        = dropped;
        held_nxt       = held_r - 5'(token_len(tk));
        pend_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      held_r       <= '0;
      row_r        <= '0;
      grp_r        <= '0;
      col_r        <= '0;
      pcol_r       <= '0;
      pvalid_r     <= 1'b0;
      fin_r        <= 1'b1;
      pend_valid_r <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      held_r       <= held_nxt;
      row_r        <= row_nxt;
      grp_r        <= grp_nxt;
      col_r        <= col_nxt;
      pcol_r       <= pcol_nxt;
      pvalid_r     <= pvalid_nxt;
      fin_r        <= fin_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Capture the decoded result
  always_ff @(posedge clk) begin
    if (cmd.step && sts.emits) begin
      if (is_end) begin
        pend_idx_r    <= '0;
        pend_col_r    <= '0;
        pend_val_r    <= '0;
        pend_dict_r   <= 1'b0;
        pend_newcol_r <= 1'b0;
        pend_done_r   <= 1'b1;
      end else begin
        pend_idx_r    <= {grp_r, row_sum[3:0]};
        pend_col_r    <= col_ext[47:0];
        pend_val_r    <= win_r[71:8];
        pend_dict_r   <= (tk < 3'd5);
        pend_newcol_r <= !pvalid_r || (pcol_r != col_step);
        pend_done_r   <= 1'b0;
      end
    end
  end

  // Write and read the dictionary
  always_ff @(posedge clk) begin
    if (cmd.load && (in_kind == IN_DICT_LOAD)) dict_mem[in_dict_index[AW-1:0]] <= in_data_word;
    if (dict_rd) dict_q <= dict_mem[win_r[8 +: AW]];
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n)         out_valid <= 1'b0;
    else if (push)      out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_result_index <= pend_idx_r;
      out_column_index <= pend_col_r;
      out_value_bits   <= pend_dict_r ? dict_q : pend_val_r;
      out_new_column   <= pend_newcol_r;
      out_done_res     <= pend_done_r;
      out_last         <= cmd.flush;
    end
  end

  `SMTD_ASSERT(a_no_overwrite, !(push && out_valid && !out_ready), "result beat overwritten")
  `SMTD_ASSERT(a_append, cmd.load && is_stream && !fin_r |=> held_r >= 5'd8, "word not appended")
  `SMTD_ASSERT(a_done_last, out_valid && out_done_res |-> out_last && out_value_bits == 64'd0,
               "end result malformed")

endmodule

// ===== sv/sparse_matrix_token_decoder_unit.sv =====
// Top level of the sparse matrix token decoder.
// Depends on smtd_pkg, smtd_if, smtd_ctrl and smtd_datapath.

// Takes dictionary loads, matrix starts and 8-byte stream words on in_ch and
// returns one beat per nonzero, plus an end-of-matrix beat, on out_ch. A stream
// word for a live matrix is first appended to the byte window; tokens are then
// decoded one at a time from its front while 16 or more bytes are buffered, by
// the single token decoder with its one-deep result hold; the pending result is
// then handed over as the last one. in_ch takes no new beat until this is done.
// Stalls on out_ch hold the decode. Dictionary entries never loaded read undefined.
module sparse_matrix_token_decoder_unit
  import smtd_pkg::*;
#(
  parameter int DICT_ENTRIES = 256,
  parameter int COLUMN_BITS  = 48
) (
  input logic          clk,
  input logic          rst_n,
  smtd_in_if.sink      in_ch,
  smtd_out_if.source   out_ch
);

  smtd_cmd_t cmd;
  smtd_sts_t sts;

  smtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smtd_datapath #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .COLUMN_BITS  (COLUMN_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_ch.kind),
    .in_dict_index    (in_ch.dict_index),
    .in_data_word     (in_ch.data_word),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_result_index (out_ch.result_index),
    .out_column_index (out_ch.column_index),
    .out_value_bits   (out_ch.value_bits),
    .out_new_column   (out_ch.new_column),
    .out_done_res     (out_ch.done_res),
    .out_last         (out_ch.last)
  );

endmodule
